>>> rtl/abr_pkg.sv
// abr_pkg: shared types and constants of the booth/restoring arithmetic unit
// used by abr_entry, abr_cell and alu_8bit_booth_restoring; no dependencies
`default_nettype none

package abr_pkg;

  localparam int FIELD_BITS        = 8;
  localparam int OPERAND_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic prev;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/abr_entry.sv
// abr_entry: registers an accepted request at the head of the cell chain
// and resolves add and subtract; depends on abr_pkg
`default_nettype none

module abr_entry #(
  parameter int OPERAND_BITS = abr_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    take,
  input  wire abr_pkg::cmd_t           cmd,
  input  wire logic [OPERAND_BITS-1:0] q_i,
  input  wire logic [OPERAND_BITS-1:0] m_i,
  output abr_pkg::ctrl_t               ctrl_o,
  output logic [OPERAND_BITS-1:0]      a_o,
  output logic [OPERAND_BITS-1:0]      q_o,
  output logic [OPERAND_BITS-1:0]      m_o
);

  abr_pkg::ctrl_t          ctrl_r, ctrl_nxt;
  logic [OPERAND_BITS-1:0] a_r, a_nxt;
  logic [OPERAND_BITS-1:0] q_r, q_nxt;
  logic [OPERAND_BITS-1:0] m_r;

  always_comb begin
    ctrl_nxt.valid = take;
    ctrl_nxt.cmd   = cmd;
    ctrl_nxt.prev  = 1'b0;
    a_nxt          = '0;
    case (cmd)
      abr_pkg::CMD_ADD: q_nxt = q_i + m_i;
      abr_pkg::CMD_SUB: q_nxt = q_i - m_i;
      default:          q_nxt = q_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
      ctrl_r.cmd   <= abr_pkg::CMD_ADD;
      ctrl_r.prev  <= 1'b0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    q_r <= q_nxt;
    m_r <= m_i;
  end

  assign ctrl_o = ctrl_r;
  assign a_o    = a_r;
  assign q_o    = q_r;
  assign m_o    = m_r;

endmodule

`default_nettype wire

>>> rtl/abr_cell.sv
// abr_cell: one booth or restoring step of the chain, registered
// add and subtract pass through unchanged; depends on abr_pkg
`default_nettype none

module abr_cell #(
  parameter int OPERAND_BITS = abr_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire abr_pkg::ctrl_t          ctrl_i,
  input  wire logic [OPERAND_BITS-1:0] a_i,
  input  wire logic [OPERAND_BITS-1:0] q_i,
  input  wire logic [OPERAND_BITS-1:0] m_i,
  output abr_pkg::ctrl_t               ctrl_o,
  output logic [OPERAND_BITS-1:0]      a_o,
  output logic [OPERAND_BITS-1:0]      q_o,
  output logic [OPERAND_BITS-1:0]      m_o
);

  localparam int W = OPERAND_BITS;

  abr_pkg::ctrl_t ctrl_r, ctrl_nxt;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   q_r, q_nxt;
  logic [W-1:0]   m_r;
  logic [W-1:0]   acc;
  logic [W-1:0]   shl_a;
  logic [W-1:0]   trial;

  always_comb begin
    ctrl_nxt = ctrl_i;
    a_nxt    = a_i;
    q_nxt    = q_i;
    acc      = a_i;
    shl_a    = {a_i[W-2:0], q_i[W-1]};
    trial    = shl_a - m_i;
    case (ctrl_i.cmd)
      abr_pkg::CMD_MUL: begin
        // booth recoding of q0 and the previous bit
        if (q_i[0] && !ctrl_i.prev) begin
          acc = a_i - m_i;
        end else if (!q_i[0] && ctrl_i.prev) begin
          acc = a_i + m_i;
        end
        ctrl_nxt.prev = q_i[0];
        q_nxt         = {acc[0], q_i[W-1:1]};
        a_nxt         = {acc[W-1], acc[W-1:1]};
      end
      abr_pkg::CMD_DIV: begin
        if (!trial[W-1]) begin
          a_nxt = trial;
          q_nxt = {q_i[W-2:0], 1'b1};
        end else begin
          a_nxt = shl_a;
          q_nxt = {q_i[W-2:0], 1'b0};
        end
      end
      default: begin
        a_nxt = a_i;
        q_nxt = q_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
      ctrl_r.cmd   <= abr_pkg::CMD_ADD;
      ctrl_r.prev  <= 1'b0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    q_r <= q_nxt;
    m_r <= m_i;
  end

  assign ctrl_o = ctrl_r;
  assign a_o    = a_r;
  assign q_o    = q_r;
  assign m_o    = m_r;

`ifndef SYNTHESIS
  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.valid |=> ctrl_r.valid)
    else $error("request lost in cell");

  a_addsub_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_i.valid && (ctrl_i.cmd == abr_pkg::CMD_ADD || ctrl_i.cmd == abr_pkg::CMD_SUB))
    |=> (q_r == $past(q_i) && a_r == $past(a_i)))
    else $error("add or subtract altered in cell");

  a_div_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_i.valid && ctrl_i.cmd == abr_pkg::CMD_DIV) |=> (q_r[0] == !a_r[W-1] || !q_r[0]))
    else $error("quotient bit set with negative remainder");
`endif

endmodule

`default_nettype wire

>>> rtl/alu_8bit_booth_restoring.sv
// alu_8bit_booth_restoring: top level of the booth multiply / restoring divide unit
// depends on abr_pkg, abr_entry and abr_cell
//
// usage:
//   a request is taken at a rising edge with start high and busy low; it carries
//   in_cmd (add, subtract, booth multiply, restoring divide), in_operand_q and
//   in_operand_m. busy is set by reset and clears at the first rising edge with rst_n high.
//   a new request may be issued every cycle while busy is low.
//   each result shows on out_result_low / out_result_high for one cycle, marked
//   by out_valid; the receiver cannot stall, so results must be taken then.
//   every command passes one entry register plus one cell per multiply or divide
//   step; add and subtract ride the same chain so results leave in request order.
//   throughput is one request per cycle while busy is low.
//   result_high is zero for add and subtract, the product high half for
//   multiply and the remainder for divide.
//   reset (synchronous, rst_n low) drops every request in flight; no result
//   is produced for them.
`default_nettype none

module alu_8bit_booth_restoring #(
  parameter int OPERAND_BITS = abr_pkg::OPERAND_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_cmd,
  input  wire logic [abr_pkg::FIELD_BITS-1:0] in_operand_q,
  input  wire logic [abr_pkg::FIELD_BITS-1:0] in_operand_m,
  output logic                                out_valid,
  output logic [abr_pkg::FIELD_BITS-1:0]      out_result_low,
  output logic [abr_pkg::FIELD_BITS-1:0]      out_result_high
);

  localparam int W  = OPERAND_BITS;
  localparam int FB = abr_pkg::FIELD_BITS;

  logic           busy_r;
  logic           take;
  logic [W-1:0]   q_in;
  logic [W-1:0]   m_in;
  abr_pkg::ctrl_t ctrl_c [W+1];
  logic [W-1:0]   a_c    [W+1];
  logic [W-1:0]   q_c    [W+1];
  logic [W-1:0]   m_c    [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign take = start && !busy_r;
  assign q_in = W'(in_operand_q);
  assign m_in = W'(in_operand_m);

  abr_entry #(
    .OPERAND_BITS(W)
  ) u_entry (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .cmd    (abr_pkg::cmd_t'(in_cmd)),
    .q_i    (q_in),
    .m_i    (m_in),
    .ctrl_o (ctrl_c[0]),
    .a_o    (a_c[0]),
    .q_o    (q_c[0]),
    .m_o    (m_c[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    abr_cell #(
      .OPERAND_BITS(W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_c[i]),
      .a_i    (a_c[i]),
      .q_i    (q_c[i]),
      .m_i    (m_c[i]),
      .ctrl_o (ctrl_c[i+1]),
      .a_o    (a_c[i+1]),
      .q_o    (q_c[i+1]),
      .m_o    (m_c[i+1])
    );
  end

  assign out_valid       = ctrl_c[W].valid;
  assign out_result_low  = FB'(q_c[W]);
  assign out_result_high = FB'(a_c[W]);

`ifndef SYNTHESIS
  a_addsub_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (ctrl_c[W].cmd == abr_pkg::CMD_ADD || ctrl_c[W].cmd == abr_pkg::CMD_SUB))
    |-> out_result_high == '0)
    else $error("nonzero high result for add or subtract");

  a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> ctrl_c[0].valid)
    else $error("accepted request not registered");

  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");
`endif

endmodule

`default_nettype wire
